/* design/shf_pkg.sv */
// Shared types, constants and round functions for the SuperFastHash core.
// No dependencies; imported by every module in this folder except the checker.
package shf_pkg;

	localparam int unsigned HASH_W          = 32;
	localparam int unsigned LEN_W           = 31;
	localparam int unsigned NB_W            = 3;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// One finished message waiting for the avalanche
	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic              zero_len;
	} entry_t;

	// Main loop round for a full four-byte word
	function automatic logic [31:0] full_round(input logic [31:0] h, input logic [31:0] w);
		logic [31:0] h1;
		logic [31:0] t;
		logic [31:0] h2;
		h1 = h + {16'd0, w[15:0]};
		t  = {5'd0, w[31:16], 11'd0} ^ h1;
		h2 = {h1[15:0], 16'd0} ^ t;
		return h2 + {11'd0, h2[31:11]};
	endfunction

	// Tail rule for three remaining bytes
	function automatic logic [31:0] tail3(input logic [31:0] h, input logic [31:0] w);
		logic [31:0] a;
		a = h + {16'd0, w[15:0]};
		a = a ^ {a[15:0], 16'd0};
		a = a ^ {6'd0, w[23:16], 18'd0};
		return a + {11'd0, a[31:11]};
	endfunction

	// Tail rule for two remaining bytes
	function automatic logic [31:0] tail2(input logic [31:0] h, input logic [31:0] w);
		logic [31:0] a;
		a = h + {16'd0, w[15:0]};
		a = a ^ {a[20:0], 11'd0};
		return a + {17'd0, a[31:17]};
	endfunction

	// Tail rule for one remaining byte
	function automatic logic [31:0] tail1(input logic [31:0] h, input logic [31:0] w);
		logic [31:0] a;
		a = h + {24'd0, w[7:0]};
		a = a ^ {a[21:0], 10'd0};
		return a + {1'd0, a[31:1]};
	endfunction

	// First half of the final avalanche (shift 3, 5, 4)
	function automatic logic [31:0] aval_a(input logic [31:0] h);
		logic [31:0] a;
		a = h ^ {h[28:0], 3'd0};
		a = a + {5'd0, a[31:5]};
		return a ^ {a[27:0], 4'd0};
	endfunction

	// Second half of the final avalanche (shift 17, 25, 6)
	function automatic logic [31:0] aval_b(input logic [31:0] h);
		logic [31:0] a;
		a = h + {17'd0, h[31:17]};
		a = a ^ {a[6:0], 25'd0};
		return a + {6'd0, a[31:6]};
	endfunction

endpackage

/* design/shf_front.sv */
// Front end: accepts word beats, keeps the running hash and hands finished
// messages to the queue. Depends on shf_pkg.
module shf_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic                     first_word,
	input  logic                     last_word,
	input  logic [shf_pkg::LEN_W-1:0] message_length,
	input  logic [31:0]              data_word,
	input  logic [shf_pkg::NB_W-1:0] valid_bytes,
	output logic                     q_push,
	output shf_pkg::entry_t          q_entry
);
	import shf_pkg::*;

	logic [HASH_W-1:0] hash_q;
	logic              in_msg_q;
	logic              zero_q;

	logic [HASH_W-1:0] seed;
	logic [HASH_W-1:0] next_hash;
	logic              zero_now;
	logic              active;

	// Seed on a first beat, otherwise carry on from the running hash
	assign seed     = first_word ? {1'b0, message_length} : hash_q;
	assign zero_now = first_word ? (message_length == '0) : zero_q;
	assign active   = first_word | in_msg_q;

	// Round selected by the byte count; counts above four act as a full word
	always_comb begin
		case (valid_bytes) inside
			3'd1:                     next_hash = tail1(seed, data_word);
			3'd2:                     next_hash = tail2(seed, data_word);
			3'd3:                     next_hash = tail3(seed, data_word);
			3'd4, 3'd5, 3'd6, 3'd7:  next_hash = full_round(seed, data_word);
			default:                  next_hash = seed;
		endcase
	end

	// Message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q   <= '0;
			in_msg_q <= 1'b0;
			zero_q   <= 1'b0;
		end else if (accept && active) begin
			hash_q   <= next_hash;
			zero_q   <= zero_now;
			in_msg_q <= ~last_word;
		end
	end

	// A last beat of an open message closes it into the queue
	assign q_push           = accept & active & last_word;
	assign q_entry.hash     = next_hash;
	assign q_entry.zero_len = zero_now;

endmodule

/* design/shf_queue.sv */
// Short register queue between the front and back ends.
// Depends on shf_pkg for the entry type.
module shf_queue #(
	parameter int unsigned DEPTH = shf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  shf_pkg::entry_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output shf_pkg::entry_t rd_data,
	output logic            not_empty
);
	import shf_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/shf_back.sv */
// Back end: two-stage avalanche pipeline ending in the result register.
// Depends on shf_pkg.
module shf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  shf_pkg::entry_t q_entry,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output logic [31:0]     hash_value
);
	import shf_pkg::*;

	logic              v_s1;
	logic              v_s2;
	logic [HASH_W-1:0] hash_s1;
	logic              zero_s1;
	logic [HASH_W-1:0] hash_s2;
	logic              en_s1;
	logic              en_s2;

	// A stage loads when it is free or its contents move on
	assign en_s2 = ~v_s2 | pop;
	assign en_s1 = ~v_s1 | en_s2;
	assign q_pop = q_valid & en_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= q_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	// Payload; zero-length messages give zero
	always_ff @(posedge clk) begin
		if (en_s1) begin
			hash_s1 <= aval_a(q_entry.hash);
			zero_s1 <= q_entry.zero_len;
		end
		if (en_s2 && v_s1) begin
			hash_s2 <= zero_s1 ? '0 : aval_b(hash_s1);
		end
	end

	assign empty      = ~v_s2;
	assign hash_value = hash_s2;

endmodule

/* design/super_fast_hash_32_core.sv */
// SuperFastHash core: one word beat per cycle while full is low.
// The hash passes through the queue, then both avalanche stages.
// Throughput: one beat per cycle while not full; the hash round sets it.
// full rises only when the result register is held and the queue fills.
// arst_n clears message state, queue and pipeline; no message is open.
module super_fast_hash_32_core #(
	parameter int unsigned QUEUE_DEPTH = shf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      first_word,
	input  logic                      last_word,
	input  logic [shf_pkg::LEN_W-1:0] message_length,
	input  logic [31:0]               data_word,
	input  logic [shf_pkg::NB_W-1:0]  valid_bytes,
	output logic                      empty,
	input  logic                      pop,
	output logic [31:0]               hash_value
);
	import shf_pkg::*;

	logic   accept;
	logic   q_push;
	logic   q_pop;
	logic   q_valid;
	entry_t q_wr;
	entry_t q_rd;

	assign accept = push & ~full;

	shf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.first_word     (first_word),
		.last_word      (last_word),
		.message_length (message_length),
		.data_word      (data_word),
		.valid_bytes    (valid_bytes),
		.q_push         (q_push),
		.q_entry        (q_wr)
	);

	shf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (q_push),
		.wr_data   (q_wr),
		.full      (full),
		.rd_en     (q_pop),
		.rd_data   (q_rd),
		.not_empty (q_valid)
	);

	shf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_entry    (q_rd),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value)
	);

endmodule

/* design/shf_checker.sv */
// Port-level checks for the SuperFastHash core, bound to the top level.
// Depends only on the top level's ports.
module shf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [31:0] hash_value
);

	// Coming out of reset no result is waiting
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result shown straight after reset");

	// The queue only backs up behind a held result
	a_full_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("full while no result waits");

	// full rises only right after the result was held and not popped
	a_full_after_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(!empty && !pop))
		else $error("full rose without a stalled result");

	// A waiting result beat holds until it is taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(hash_value)))
		else $error("result beat changed before pop");

endmodule

bind super_fast_hash_32_core shf_checker u_shf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.hash_value (hash_value)
);

/* tb/tb_super_fast_hash_32_core.sv */
// Self-checking testbench for super_fast_hash_32_core: random and directed message streams.
// Holds its own SuperFastHash predictor in a small scoreboard class.
// Depends on shf_pkg and super_fast_hash_32_core from the design folder.
module tb_super_fast_hash_32_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ITEM_TARGET = 1450;
	localparam int unsigned IDLE_LIMIT  = 1000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned DRAIN_WAIT  = 10;

	// Expected hashes and the running state of the message in flight
	class hash_scoreboard;
		bit [31:0]   run_hash;
		bit          open;
		bit          zero_len;
		bit [31:0]   expected_hashes[$];
		int unsigned mismatches;

		function bit [31:0] mix_word(bit [31:0] h, bit [31:0] w);
			bit [31:0] t;
			h = h + {16'h0, w[15:0]};
			t = ({16'h0, w[31:16]} << 11) ^ h;
			h = (h << 16) ^ t;
			return h + (h >> 11);
		endfunction

		function bit [31:0] mix_tail(bit [31:0] h, bit [31:0] w, bit [2:0] n);
			case (n)
				3'd3: begin
					h = h + {16'h0, w[15:0]};
					h = h ^ (h << 16);
					h = h ^ ({24'h0, w[23:16]} << 18);
					h = h + (h >> 11);
				end
				3'd2: begin
					h = h + {16'h0, w[15:0]};
					h = h ^ (h << 11);
					h = h + (h >> 17);
				end
				3'd1: begin
					h = h + {24'h0, w[7:0]};
					h = h ^ (h << 10);
					h = h + (h >> 1);
				end
				default: ;
			endcase
			return h;
		endfunction

		function bit [31:0] finalise(bit [31:0] h);
			h = h ^ (h << 3);
			h = h + (h >> 5);
			h = h ^ (h << 4);
			h = h + (h >> 17);
			h = h ^ (h << 25);
			return h + (h >> 6);
		endfunction

		// Returns 1 when the beat was not ignored by an idle block
		function bit note_beat(bit first, bit last, bit [30:0] len, bit [31:0] word,
			bit [2:0] nb);
			bit [2:0] n;
			n = (nb > 3'd4) ? 3'd4 : nb;
			if (first) begin
				run_hash = {1'b0, len};
				open     = 1'b1;
				zero_len = (len == 31'd0);
			end
			if (!open)
				return 1'b0;
			run_hash = (n == 3'd4) ? mix_word(run_hash, word) : mix_tail(run_hash, word, n);
			if (last) begin
				expected_hashes.push_back(zero_len ? 32'h0 : finalise(run_hash));
				open = 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_hash(bit [31:0] got);
			bit [31:0] want;
			if (expected_hashes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected hash beat: got %08h", got);
				return;
			end
			want = expected_hashes.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("hash_value mismatch: expected %08h got %08h", want, got);
			end
		endfunction

		function int unsigned pending();
			return expected_hashes.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n         = 1'b0;
	logic                          push           = 1'b0;
	logic                          full;
	logic                          first_word     = 1'b0;
	logic                          last_word      = 1'b0;
	logic [shf_pkg::LEN_W-1:0]     message_length = '0;
	logic [31:0]                   data_word      = '0;
	logic [shf_pkg::NB_W-1:0]      valid_bytes    = '0;
	logic                          empty;
	logic                          pop            = 1'b0;
	logic [31:0]                   hash_value;

	hash_scoreboard sb = new();
	int unsigned    beats_used;
	int unsigned    cyc;
	int unsigned    idle_cycles;
	bit             hold_req;

	super_fast_hash_32_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.first_word     (first_word),
		.last_word      (last_word),
		.message_length (message_length),
		.data_word      (data_word),
		.valid_bytes    (valid_bytes),
		.empty          (empty),
		.pop            (pop),
		.hash_value     (hash_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 93)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	// Quiet windows with no idling on either side
	function automatic bit calm();
		return (cyc % 900) >= 720;
	endfunction

	// Offer one beat, wait for it to be taken, then maybe leave a gap
	task automatic send_beat(bit first, bit last, bit [30:0] len, bit [31:0] word,
		bit [2:0] nb, bit allow_gap = 1'b1);
		int unsigned g;
		first_word     <= first;
		last_word      <= last;
		message_length <= len;
		data_word      <= word;
		valid_bytes    <= nb;
		push           <= 1'b1;
		do @(posedge clk); while (full);
		if (sb.note_beat(first, last, len, word, nb))
			beats_used++;
		if (allow_gap && !calm() && $urandom_range(0, 99) < 30) begin
			g = gap_len();
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Well-formed message with random content; a few break off or lie about the length
	task automatic send_message();
		int unsigned r;
		int unsigned nbytes;
		int unsigned nbeats;
		int unsigned stop_at;
		bit [30:0]   len;
		bit [2:0]    nb;
		r = $urandom_range(0, 99);
		if (r < 5)
			nbytes = 0;
		else if (r < 80)
			nbytes = $urandom_range(1, 16);
		else if (r < 95)
			nbytes = $urandom_range(17, 40);
		else
			nbytes = $urandom_range(41, 128);
		nbeats  = (nbytes == 0) ? 1 : (nbytes + 3) / 4;
		len     = ($urandom_range(0, 99) < 8) ? 31'($urandom) : 31'(nbytes);
		stop_at = ($urandom_range(0, 99) < 4) ? $urandom_range(1, nbeats) : nbeats + 1;
		for (int unsigned i = 0; i < nbeats; i++) begin
			if (i == stop_at)
				return;
			if (nbytes == 0)
				nb = 3'd0;
			else if (i == nbeats - 1 && nbytes % 4 != 0)
				nb = 3'(nbytes % 4);
			else
				nb = 3'd4;
			// length is only read on the first beat, so other beats carry noise there
			send_beat(i == 0, i == nbeats - 1, (i == 0) ? len : 31'($urandom), $urandom, nb);
		end
	endtask

	// Receiver: random stalls, plus one long hold-off when asked
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_hash(hash_value);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !calm() && $urandom_range(0, 99) < 30) begin
				stall_left = gap_len();
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog: cycles in a row with no beat taken on either side
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			cyc++;
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle beat without a first mark is dropped
		send_beat(1'b0, 1'b1, 31'd5, 32'hDEAD_BEEF, 3'd4);
		// empty message, and a zero length that ignores its data
		send_beat(1'b1, 1'b1, 31'd0, 32'h0, 3'd0);
		send_beat(1'b1, 1'b0, 31'd0, 32'hFFFF_FFFF, 3'd4);
		send_beat(1'b0, 1'b1, 31'd0, 32'h1234_5678, 3'd3);
		// one, two, three and four byte messages
		send_beat(1'b1, 1'b1, 31'd1, 32'h0000_00FF, 3'd1);
		send_beat(1'b1, 1'b1, 31'd2, 32'h0000_FFFF, 3'd2);
		send_beat(1'b1, 1'b1, 31'd3, 32'h00FF_FFFF, 3'd3);
		send_beat(1'b1, 1'b1, 31'd4, 32'h0000_0000, 3'd4);
		// seven bytes: full word then a three byte tail
		send_beat(1'b1, 1'b0, 31'd7, 32'h6463_6261, 3'd4);
		send_beat(1'b0, 1'b1, 31'd7, 32'h0067_6665, 3'd3);
		// largest length, partial word mid-message, no-byte last beat
		send_beat(1'b1, 1'b0, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 3'd4);
		send_beat(1'b0, 1'b0, 31'h7FFF_FFFF, 32'hA5A5_A5A5, 3'd2);
		send_beat(1'b0, 1'b1, 31'h0, 32'hFFFF_FFFF, 3'd0);
		// oversized byte counts act as full words
		send_beat(1'b1, 1'b0, 31'd12, 32'h8000_0001, 3'd5);
		send_beat(1'b0, 1'b0, 31'd12, 32'h7FFF_FFFE, 3'd6);
		send_beat(1'b0, 1'b1, 31'd12, 32'hC3C3_3C3C, 3'd7);
		// new first beat while a message is open abandons it
		send_beat(1'b1, 1'b0, 31'd8, 32'h1111_1111, 3'd4);
		send_beat(1'b1, 1'b1, 31'd4, 32'h2222_2222, 3'd4);
		// length that disagrees with the bytes delivered
		send_beat(1'b1, 1'b1, 31'd100, 32'h0000_0042, 3'd1);
		send_beat(1'b1, 1'b1, 31'h5555_5555, 32'h5555_5555, 3'd4);

		// receiver holds off while single-beat messages stream in back to back
		hold_req = 1'b1;
		for (int unsigned i = 0; i < 24; i++)
			send_beat(1'b1, 1'b1, 31'($urandom_range(1, 4)), $urandom, 3'd4, 1'b0);

		// random part: mostly whole messages, some noise beats
		while (beats_used < ITEM_TARGET) begin
			if ($urandom_range(0, 99) < 10)
				send_beat($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), 31'($urandom),
					$urandom, 3'($urandom_range(0, 7)));
			else
				send_message();
		end
		push <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
